[sv/aabb_frustum_cull_defines.svh]
// Assertion macros for the culling block's top-level RTL file.
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

// Check that the antecedent implies the consequent in the same cycle.
`define AFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that the antecedent implies the consequent in the next cycle.
`define AFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/afc_pkg.sv]
// Types, widths and constants shared by the culling block's modules.
package afc_pkg;

  localparam int COORD_W     = 32;
  localparam int PROD_W      = 64;
  localparam int XY_W        = 66;
  localparam int CLIP_W      = 67;
  localparam int TEST_W      = 68;
  localparam int NUM_ROWS    = 4;
  localparam int NUM_COLS    = 4;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_REGS    = 8;
  localparam int REG_W       = 64;
  localparam int IDX_W       = 4;
  localparam int NUM_PLANES  = 6;

  // Outcode bit positions
  localparam int PL_LEFT   = 0;
  localparam int PL_RIGHT  = 1;
  localparam int PL_BOTTOM = 2;
  localparam int PL_TOP    = 3;
  localparam int PL_NEAR   = 4;
  localparam int PL_FAR    = 5;

  typedef logic [COORD_W-1:0] coef_t;
  typedef coef_t [NUM_ROWS-1:0][NUM_COLS-1:0] matrix_t;
  typedef logic [REG_W-1:0] cfg_word_t;

  // Reset value of the register file: identity matrix
  localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef logic [PROD_W-1:0] prod_t;

  // Products of one matrix row; index 0 is the box minimum, 1 the maximum
  typedef struct packed {
    prod_t [1:0] px;
    prod_t [1:0] py;
    prod_t [1:0] pz;
  } row_prod_t;

  typedef row_prod_t [NUM_ROWS-1:0] prod_set_t;

  typedef logic [XY_W-1:0] xy_t;
  typedef logic [CLIP_W-1:0] clip_t;
  typedef clip_t [NUM_CORNERS-1:0] row_clip_t;
  typedef row_clip_t [NUM_ROWS-1:0] clip_set_t;

  // Signed 32 x 32 product at full 64-bit width
  function automatic prod_t mul_q16(coef_t a, logic [COORD_W-1:0] b);
    logic signed [PROD_W-1:0] ae;
    logic signed [PROD_W-1:0] be;
    logic signed [PROD_W-1:0] pe;
    ae = $signed({{(PROD_W-COORD_W){a[COORD_W-1]}}, a});
    be = $signed({{(PROD_W-COORD_W){b[COORD_W-1]}}, b});
    pe = ae * be;
    return prod_t'(pe);
  endfunction

endpackage

[sv/afc_products.sv]
// First pipeline stage: every entry of matrix columns 0 to 2 times the box bounds it meets.
module afc_products (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  afc_pkg::matrix_t         matrix,
  input  logic [31:0]              min_x,
  input  logic [31:0]              min_y,
  input  logic [31:0]              min_z,
  input  logic [31:0]              max_x,
  input  logic [31:0]              max_y,
  input  logic [31:0]              max_z,
  output logic                     out_valid,
  output afc_pkg::prod_set_t       prods
);
  import afc_pkg::*;

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Form the 24 products shared by all eight corners
  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      prods[r].px[0] <= mul_q16(matrix[r][0], min_x);
      prods[r].px[1] <= mul_q16(matrix[r][0], max_x);
      prods[r].py[0] <= mul_q16(matrix[r][1], min_y);
      prods[r].py[1] <= mul_q16(matrix[r][1], max_y);
      prods[r].pz[0] <= mul_q16(matrix[r][2], min_z);
      prods[r].pz[1] <= mul_q16(matrix[r][2], max_z);
    end
  end

endmodule

[sv/afc_corner_sum.sv]
// Second and third pipeline stages: sum products into clip coordinates per corner.
module afc_corner_sum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  afc_pkg::matrix_t     matrix,
  input  afc_pkg::prod_set_t   prods,
  output logic                 out_valid,
  output afc_pkg::clip_set_t   clips
);
  import afc_pkg::*;

  logic                        xy_valid;
  xy_t  [NUM_ROWS-1:0][3:0]    xy_sum;
  prod_t [NUM_ROWS-1:0][1:0]   pz_dly;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      xy_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      xy_valid  <= in_valid;
      out_valid <= xy_valid;
    end
  end

  genvar r, j, c;
  generate
    for (r = 0; r < NUM_ROWS; r++) begin : g_row
      // Translation term: column 3 times 1.0 in Q16.16
      xy_t w_term;
      assign w_term = {{(XY_W-COORD_W-16){matrix[r][3][COORD_W-1]}}, matrix[r][3], 16'b0};

      // Sum x and y products plus translation for the four x/y combinations
      for (j = 0; j < 4; j++) begin : g_xy
        always_ff @(posedge clk) begin
          xy_sum[r][j] <=
            {{(XY_W-PROD_W){prods[r].px[j%2][PROD_W-1]}}, prods[r].px[j%2]} +
            {{(XY_W-PROD_W){prods[r].py[j/2][PROD_W-1]}}, prods[r].py[j/2]} +
            w_term;
        end
      end

      // Hold the z products alongside the partial sums
      always_ff @(posedge clk) begin
        pz_dly[r] <= prods[r].pz;
      end

      // Add the z product to finish each corner
      for (c = 0; c < NUM_CORNERS; c++) begin : g_corner
        always_ff @(posedge clk) begin
          clips[r][c] <=
            {{(CLIP_W-XY_W){xy_sum[r][c%4][XY_W-1]}}, xy_sum[r][c%4]} +
            {{(CLIP_W-PROD_W){pz_dly[r][c/4][PROD_W-1]}}, pz_dly[r][c/4]};
        end
      end
    end
  endgenerate

endmodule

[sv/afc_plane_test.sv]
// Last pipeline stage: outcodes per corner, combined into the visibility word.
module afc_plane_test (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  afc_pkg::clip_set_t   clips,
  output logic                 out_valid,
  output logic                 visible
);
  import afc_pkg::*;

  typedef logic [TEST_W-1:0] test_t;

  logic [NUM_CORNERS-1:0][NUM_PLANES-1:0] outcode;
  logic [NUM_PLANES-1:0]                  common;

  genvar c;
  generate
    for (c = 0; c < NUM_CORNERS; c++) begin : g_corner
      test_t cx, cy, cz, cw;
      test_t x_plus, x_minus, y_plus, y_minus, z_minus;

      assign cx = {clips[0][c][CLIP_W-1], clips[0][c]};
      assign cy = {clips[1][c][CLIP_W-1], clips[1][c]};
      assign cz = {clips[2][c][CLIP_W-1], clips[2][c]};
      assign cw = {clips[3][c][CLIP_W-1], clips[3][c]};

      assign x_plus  = cx + cw;
      assign x_minus = cx - cw;
      assign y_plus  = cy + cw;
      assign y_minus = cy - cw;
      assign z_minus = cz - cw;

      // Outside when the sum is negative or the difference strictly positive; near when z is negative
      always_comb begin
        outcode[c][PL_LEFT]   = x_plus[TEST_W-1];
        outcode[c][PL_RIGHT]  = !x_minus[TEST_W-1] && (x_minus != '0);
        outcode[c][PL_BOTTOM] = y_plus[TEST_W-1];
        outcode[c][PL_TOP]    = !y_minus[TEST_W-1] && (y_minus != '0);
        outcode[c][PL_NEAR]   = cz[TEST_W-1];
        outcode[c][PL_FAR]    = !z_minus[TEST_W-1] && (z_minus != '0);
      end
    end
  endgenerate

  // AND the outcodes across corners: a surviving bit culls the box
  always_comb begin
    common = '1;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      common = common & outcode[k];
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Register the result word
  always_ff @(posedge clk) begin
    visible <= (common == '0);
  end

endmodule

[sv/aabb_frustum_cull.sv]
// Top level of the box frustum culler: register file, pipeline and checks.
// Takes one box per clock (busy is never raised) and returns one visible word
// per box, strobed by done, once the box has passed its stages: a stage of 24 shared
// 32 x 32 multipliers, two adder stages that build the eight corners' clip
// coordinates, and a stage of plane compares. Results leave in input order and
// cannot be held off. Matrix writes take effect on the next box; write them only
// while no box is in the pipeline. Reset loads the identity matrix.
`include "aabb_frustum_cull_defines.svh"

module aabb_frustum_cull (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [31:0]               box_min_x,
  input  logic [31:0]               box_min_y,
  input  logic [31:0]               box_min_z,
  input  logic [31:0]               box_max_x,
  input  logic [31:0]               box_max_y,
  input  logic [31:0]               box_max_z,
  output logic                      done,
  output logic                      visible,
  input  logic                      cfg_we,
  input  logic [afc_pkg::IDX_W-1:0] cfg_index,
  input  logic [afc_pkg::REG_W-1:0] cfg_data
);
  import afc_pkg::*;

  cfg_word_t  cfg_regs [NUM_REGS];
  matrix_t    matrix;
  logic       prod_valid;
  prod_set_t  prods;
  logic       clip_valid;
  clip_set_t  clips;

  // The pipeline never stalls
  assign busy = 1'b0;

  // Load the matrix registers; drop writes beyond the last register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_regs[i] <= CFG_RESET[i];
      end
    end else if (cfg_we && (cfg_index < IDX_W'(NUM_REGS))) begin
      cfg_regs[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  // Split each register into its two Q16.16 entries
  genvar r, k;
  generate
    for (r = 0; r < NUM_ROWS; r++) begin : g_row
      for (k = 0; k < NUM_COLS; k++) begin : g_col
        assign matrix[r][k] = cfg_regs[r*2 + k/2][(k%2)*COORD_W +: COORD_W];
      end
    end
  endgenerate

  afc_products u_products (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .matrix    (matrix),
    .min_x     (box_min_x),
    .min_y     (box_min_y),
    .min_z     (box_min_z),
    .max_x     (box_max_x),
    .max_y     (box_max_y),
    .max_z     (box_max_z),
    .out_valid (prod_valid),
    .prods     (prods)
  );

  afc_corner_sum u_corner_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .matrix    (matrix),
    .prods     (prods),
    .out_valid (clip_valid),
    .clips     (clips)
  );

  afc_plane_test u_plane_test (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (clip_valid),
    .clips     (clips),
    .out_valid (done),
    .visible   (visible)
  );

  // Every result word traces back to a box taken at the pipeline's input
  `AFC_ASSERT_IMP(a_done_has_box, done, $past(start, 4))
  // Every box taken outside reset comes out as a result word strobed by done
  `AFC_ASSERT_NEXT(a_box_gives_done, $past(start && !rst, 3) && $past(!rst, 2) && $past(!rst, 1), done)

endmodule
